// ----- design/aufr_pkg.sv -----
// Package for the addressed frame receiver: result status codes,
// sync bytes and the fixed framing constants. No dependencies.
package aufr_pkg;

    // Result status codes carried in the low bits of m_tuser.
    typedef enum logic [2:0] {
        ST_BUSY          = 3'd0,
        ST_DONE          = 3'd1,
        ST_BAD_SYNC0     = 3'd2,
        ST_BAD_SYNC1     = 3'd3,
        ST_ADDR_MISMATCH = 3'd4,
        ST_OVERLENGTH    = 3'd5
    } status_t;

    localparam logic [7:0]  SYNC0_BYTE = 8'h5A;
    localparam logic [7:0]  SYNC1_BYTE = 8'hA5;
    localparam logic [15:0] BCAST_LOW  = 16'hFFFF;

    // Byte positions inside a frame.
    localparam int POS_SYNC0     = 0;
    localparam int POS_SYNC1     = 1;
    localparam int POS_ADDR_FIRST = 2;
    localparam int POS_ADDR_LAST = 4;
    localparam int POS_LENGTH    = 8;

    // Header and trailer bytes around the payload, and the count at
    // which the length field has been seen.
    localparam int LEN_OFFSET    = 10;
    localparam int LEN_SEEN_CNT  = 9;
    localparam int SUM_W         = 9;

    localparam int DATA_W   = 8;
    localparam int POS_W    = 7;
    localparam int ADDR_W   = 24;

endpackage

// ----- design/addressed_uart_frame_receiver.sv -----
// Top level of the addressed frame receiver: byte deframer with sync,
// address and length checks. Depends on aufr_pkg.
//
// Usage: received bytes enter on the s_ stream channel, one byte per
// transaction. Every byte yields exactly one result transaction on the m_
// channel that echoes the byte with its position in the frame and a
// status (in progress, frame done, bad sync, address mismatch, overlength).
// The board address register is written through cfg_we / cfg_wdata; the user
// must write it only while no transaction is in flight. The block does not enforce this.
// The result is registered: a byte accepted at an edge is shown at m_tvalid
// right after that edge. Throughput is one byte per cycle while results are
// taken; the frame state and all checks sit in one stage between the input
// port and the result register, so the frame counter loop sets the rate.
// s_tready stays high while the result register is empty or being taken,
// so a stalled receiver holds one result and then stalls the sender.
// Reset (aresetn low, synchronous) clears the address register, the frame
// state and the result valid flag.
module addressed_uart_frame_receiver
    import aufr_pkg::*;
#(
    parameter int MAX_FRAME = 120
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write: board address, byte 2 in bits 23:16.
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    // Result stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,    // [7:0] data_byte, [14:8] position,
                                            // [21:15] frame_length, [23:22] zero
    output logic [3:0]          m_tuser     // [2:0] status, [3] is_broadcast
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic [ADDR_W-1:0] board_addr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] cap_reg, cap_next;
    logic [7:0]        len_reg, len_next;
    logic              bcast_reg, bcast_next;
    logic              m_valid_reg;
    logic [23:0]       m_data_reg, m_data_next;
    logic [3:0]        m_user_reg, m_user_next;

    logic              accept;
    logic [7:0]        rx_byte;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ADDR_W-1:0] cap_shift;
    logic [SUM_W-1:0]  len_sum;
    status_t           status;
    logic [POS_W-1:0]  flen;
    logic              bcast_out;

    assign rx_byte  = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_addr_reg <= '0;
        end else if (cfg_we) begin
            board_addr_reg <= cfg_wdata;
        end
    end

    // Frame checks for the byte on the input port.
    always_comb begin
        cnt_inc    = count_reg + CNT_W'(1);
        cap_shift  = cap_reg;
        len_next   = len_reg;
        bcast_next = bcast_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        status     = ST_BUSY;
        flen       = '0;
        bcast_out  = 1'b0;
        len_sum    = '0;

        if (count_reg == CNT_W'(POS_SYNC0) && rx_byte != SYNC0_BYTE) begin
            status     = ST_BAD_SYNC0;
            count_next = '0;
            cap_next   = '0;
            len_next   = '0;
            bcast_next = 1'b0;
        end else if (count_reg == CNT_W'(POS_SYNC1) && rx_byte != SYNC1_BYTE) begin
            status     = ST_BAD_SYNC1;
            count_next = '0;
            cap_next   = '0;
            len_next   = '0;
            bcast_next = 1'b0;
        end else begin
            if (count_reg >= CNT_W'(POS_ADDR_FIRST) && count_reg <= CNT_W'(POS_ADDR_LAST)) begin
                cap_shift = {cap_reg[ADDR_W-9:0], rx_byte};
            end
            if (count_reg == CNT_W'(POS_LENGTH)) begin
                len_next = rx_byte;
            end
            len_sum    = {1'b0, len_next} + SUM_W'(LEN_OFFSET);
            count_next = cnt_inc;
            cap_next   = cap_shift;

            // Address check once the last address byte is in.
            if (count_reg == CNT_W'(POS_ADDR_LAST)) begin
                if (cap_shift[15:0] == BCAST_LOW) begin
                    bcast_next = 1'b1;
                end else if (cap_shift != board_addr_reg) begin
                    status = ST_ADDR_MISMATCH;
                end
            end

            if (status == ST_ADDR_MISMATCH) begin
                count_next = '0;
                cap_next   = '0;
                len_next   = '0;
                bcast_next = 1'b0;
            end else begin
                bcast_out = bcast_next;
                if (cnt_inc >= CNT_W'(LEN_SEEN_CNT) && SUM_W'(cnt_inc) == len_sum) begin
                    status     = ST_DONE;
                    flen       = POS_W'(cnt_inc);
                    count_next = '0;
                    cap_next   = '0;
                    len_next   = '0;
                    bcast_next = 1'b0;
                end else if (cnt_inc >= CNT_W'(MAX_FRAME)) begin
                    status     = ST_OVERLENGTH;
                    count_next = '0;
                    cap_next   = '0;
                    len_next   = '0;
                    bcast_next = 1'b0;
                end
            end
        end

        m_data_next = {2'b00, flen, POS_W'(count_reg), rx_byte};
        m_user_next = {bcast_out, status};
    end

    // Frame state, updated on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= '0;
            len_reg   <= '0;
            bcast_reg <= 1'b0;
        end else if (accept) begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
            len_reg   <= len_next;
            bcast_reg <= bcast_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- design/aufr_checker.sv -----
// Port-level checker for the addressed frame receiver, bound to the top
// level. Depends on aufr_pkg and addressed_uart_frame_receiver.
module aufr_checker
    import aufr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result is shown in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Status is always one of the defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:0] <= ST_OVERLENGTH)
        else $error("undefined status code");

    // A frame length is reported only with a completed frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] != ST_DONE |-> m_tdata[21:15] == 7'd0)
        else $error("frame length without completion");

    // A bad first sync byte always sits at position zero, never broadcast.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == ST_BAD_SYNC0 |-> m_tdata[14:8] == 7'd0 && !m_tuser[3])
        else $error("bad sync0 outside position zero");

endmodule

bind addressed_uart_frame_receiver aufr_checker u_aufr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
